>>> sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define FFAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define FFAC_NEVER(lbl, cond, msg) \
  `FFAC_ASSERT(lbl, !(cond), msg)

`endif

>>> sv/ffac_pkg.sv
// ----------------------------------------------------------------------------
// ffac_pkg
// Shared types and constants for the first-fit allocator with coalescing.
// ----------------------------------------------------------------------------
package ffac_pkg;

  localparam int POOL_SIZE    = 512;
  localparam int MAX_SEGMENTS = 256;

  localparam int AW = $clog2(POOL_SIZE);        // address bits
  localparam int LW = $clog2(POOL_SIZE + 1);    // length bits
  localparam int CW = $clog2(MAX_SEGMENTS + 1); // segment count bits
  localparam int IW = $clog2(MAX_SEGMENTS);     // table index bits

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_A_RD,
    S_A_CHK,
    S_F_RD,
    S_F_CHK,
    S_F_DEC,
    S_DN_RD,
    S_DN_WR,
    S_UP_RD,
    S_UP_WR,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_SH_NEXT,
    RD_SH_PREV
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_SHRINK,
    WR_PREV,
    WR_NEXT,
    WR_NEW,
    WR_SHIFT
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    idx_inc;
    logic    take_prev;
    logic    grant;
    logic    sh_from_idx;
    logic    sh_from_count;
    logic    sh_inc;
    logic    sh_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic skip;
    logic idx_lt_count;
    logic fit;
    logic exact;
    logic start_le_addr;
    logic join_next;
    logic join_prev;
    logic full;
    logic sh_next_lt_count;
    logic sh_gt_idx;
    logic out_busy;
  } dp_status_t;

endpackage

>>> sv/ffac_ctrl.sv
// ----------------------------------------------------------------------------
// ffac_ctrl
// Sequencer: table scan, shift loops and result hand-off.
// ----------------------------------------------------------------------------
module ffac_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffac_pkg::dp_status_t st_i,
  output ffac_pkg::ctrl_cmd_t  cmd_o
);
  import ffac_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        if (st_i.skip) state_d = S_DONE;
        else if (st_i.is_free) state_d = S_F_RD;
        else state_d = S_A_RD;
      end
      S_A_RD: begin
        state_d = st_i.idx_lt_count ? S_A_CHK : S_DONE;
      end
      S_A_CHK: begin
        if (!st_i.fit) state_d = S_A_RD;
        else if (st_i.exact) state_d = S_DN_RD;
        else state_d = S_DONE;
      end
      S_F_RD: begin
        state_d = st_i.idx_lt_count ? S_F_CHK : S_F_DEC;
      end
      S_F_CHK: begin
        state_d = st_i.start_le_addr ? S_F_RD : S_F_DEC;
      end
      S_F_DEC: begin
        if (st_i.join_prev && st_i.join_next) state_d = S_DN_RD;
        else if (st_i.join_prev || st_i.join_next) state_d = S_DONE;
        else if (!st_i.full) state_d = S_UP_RD;
        else state_d = S_DONE;
      end
      S_DN_RD: begin
        state_d = st_i.sh_next_lt_count ? S_DN_WR : S_DONE;
      end
      S_DN_WR: state_d = S_DN_RD;
      S_UP_RD: begin
        state_d = st_i.sh_gt_idx ? S_UP_WR : S_DONE;
      end
      S_UP_WR: state_d = S_UP_RD;
      S_DONE: begin
        if (!st_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_IDX;
    cmd_o.wr_sel = WR_SHRINK;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_START: ;
      S_A_RD: begin
        cmd_o.rd_en = st_i.idx_lt_count;
      end
      S_A_CHK: begin
        if (st_i.fit) begin
          cmd_o.grant = 1'b1;
          if (st_i.exact) begin
            cmd_o.sh_from_idx = 1'b1;
          end else begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_SHRINK;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_F_RD: begin
        cmd_o.rd_en = st_i.idx_lt_count;
      end
      S_F_CHK: begin
        if (st_i.start_le_addr) begin
          cmd_o.take_prev = 1'b1;
          cmd_o.idx_inc   = 1'b1;
        end
      end
      S_F_DEC: begin
        if (st_i.join_prev) begin
          cmd_o.wr_en       = 1'b1;
          cmd_o.wr_sel      = WR_PREV;
          cmd_o.sh_from_idx = st_i.join_next;
        end else if (st_i.join_next) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_NEXT;
        end else begin
          cmd_o.sh_from_count = !st_i.full;
        end
      end
      S_DN_RD: begin
        if (st_i.sh_next_lt_count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_SH_NEXT;
        end else begin
          cmd_o.cnt_dec = 1'b1;
        end
      end
      S_DN_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.sh_inc = 1'b1;
      end
      S_UP_RD: begin
        if (st_i.sh_gt_idx) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_SH_PREV;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WR_NEW;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_UP_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.sh_dec = 1'b1;
      end
      S_DONE: begin
        cmd_o.res_load = !st_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/ffac_dpath.sv
// ----------------------------------------------------------------------------
// ffac_dpath
// Segment table memory, scan pointers, merge arithmetic and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffac_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         command_i,
  input  logic [ffac_pkg::AW-1:0]      block_address_i,
  input  logic [ffac_pkg::LW-1:0]      block_size_i,
  input  ffac_pkg::ctrl_cmd_t          cmd_i,
  output ffac_pkg::dp_status_t         st_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [ffac_pkg::AW-1:0]      granted_address_o,
  output logic [ffac_pkg::CW-1:0]      free_segments_o
);
  import ffac_pkg::*;

  localparam logic [LW:0] POOL_X = (LW + 1)'(POOL_SIZE);

  // segment table
  logic [AW-1:0] mem_start [MAX_SEGMENTS];
  logic [LW-1:0] mem_len   [MAX_SEGMENTS];

  logic          cmd_q;
  logic [AW-1:0] addr_q;
  logic [LW-1:0] size_q;
  logic          skip_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] sh_q;
  logic [CW-1:0] count_q;
  logic [AW-1:0] prev_start_q;
  logic [LW-1:0] prev_len_q;
  logic          ok_q;
  logic [AW-1:0] grant_q;
  logic          init_q;
  logic          rd_init_q;
  logic [AW-1:0] rd_start_q;
  logic [LW-1:0] rd_len_q;
  logic          out_valid_q;
  logic [1:0]    res_status_q;
  logic [AW-1:0] res_granted_q;
  logic [CW-1:0] res_count_q;

  logic [AW-1:0] rd_start;
  logic [LW-1:0] rd_len;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;
  logic [AW-1:0] wr_start;
  logic [LW-1:0] wr_len;
  logic [LW:0]   room;
  logic [LW-1:0] size_clip;
  logic          skip_in;
  logic [LW-1:0] merged;
  logic          join_next;
  logic          join_prev;
  logic [CW-1:0] sh_next;
  logic [CW-1:0] sh_prev;
  logic [CW-1:0] idx_prev;

  function automatic logic [LW-1:0] sat_len(input logic [LW:0] v);
    return (v > POOL_X) ? POOL_X[LW-1:0] : v[LW-1:0];
  endfunction

  // entry 0 reads as the whole pool until it is first written
  assign rd_start = rd_init_q ? '0 : rd_start_q;
  assign rd_len   = rd_init_q ? POOL_X[LW-1:0] : rd_len_q;

  // clip a free to the pool end; drop zero sizes and addresses off the pool
  assign room      = POOL_X - (LW + 1)'(block_address_i);
  assign size_clip = (command_i == CMD_FREE && (LW + 1)'(block_size_i) > room)
                     ? room[LW-1:0] : block_size_i;
  assign skip_in   = (block_size_i == '0) ||
                     (command_i == CMD_FREE && (LW + 1)'(block_address_i) >= POOL_X);

  assign sh_next  = sh_q + CW'(1);
  assign sh_prev  = sh_q - CW'(1);
  assign idx_prev = idx_q - CW'(1);

  assign join_next = (idx_q < count_q) &&
                     ((LW + 1)'(rd_start) == (LW + 1)'(addr_q) + (LW + 1)'(size_q));
  assign join_prev = (idx_q != '0) &&
                     ((LW + 1)'(prev_start_q) + (LW + 1)'(prev_len_q) ==
                      (LW + 1)'(addr_q));
  assign merged    = join_next ? sat_len((LW + 1)'(size_q) + (LW + 1)'(rd_len)) : size_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:     rd_idx = idx_q[IW-1:0];
      RD_SH_NEXT: rd_idx = sh_next[IW-1:0];
      RD_SH_PREV: rd_idx = sh_prev[IW-1:0];
      default:    rd_idx = idx_q[IW-1:0];
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_SHRINK: begin
        wr_idx   = idx_q[IW-1:0];
        wr_start = AW'((LW + 1)'(rd_start) + (LW + 1)'(size_q));
        wr_len   = rd_len - size_q;
      end
      WR_PREV: begin
        wr_idx   = idx_prev[IW-1:0];
        wr_start = prev_start_q;
        wr_len   = sat_len((LW + 1)'(prev_len_q) + (LW + 1)'(merged));
      end
      WR_NEXT: begin
        wr_idx   = idx_q[IW-1:0];
        wr_start = addr_q;
        wr_len   = merged;
      end
      WR_NEW: begin
        wr_idx   = idx_q[IW-1:0];
        wr_start = addr_q;
        wr_len   = size_q;
      end
      WR_SHIFT: begin
        wr_idx   = sh_q[IW-1:0];
        wr_start = rd_start;
        wr_len   = rd_len;
      end
      default: begin
        wr_idx   = idx_q[IW-1:0];
        wr_start = addr_q;
        wr_len   = size_q;
      end
    endcase
  end

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_start[wr_idx] <= wr_start;
      mem_len[wr_idx]   <= wr_len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_start_q <= mem_start[rd_idx];
      rd_len_q   <= mem_len[rd_idx];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CW'(1);
      init_q      <= 1'b1;
      rd_init_q   <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      sh_q        <= '0;
      ok_q        <= 1'b0;
    end else begin
      if (cmd_i.wr_en && wr_idx == '0) init_q <= 1'b0;
      if (cmd_i.rd_en) rd_init_q <= init_q && (rd_idx == '0);
      if (cmd_i.cnt_inc) count_q <= count_q + CW'(1);
      else if (cmd_i.cnt_dec) count_q <= count_q - CW'(1);

      if (cmd_i.load) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + CW'(1);

      if (cmd_i.sh_from_idx) sh_q <= idx_q;
      else if (cmd_i.sh_from_count) sh_q <= count_q;
      else if (cmd_i.sh_inc) sh_q <= sh_next;
      else if (cmd_i.sh_dec) sh_q <= sh_prev;

      if (cmd_i.load) ok_q <= 1'b0;
      else if (cmd_i.grant) ok_q <= 1'b1;

      if (cmd_i.res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= command_i;
      addr_q  <= block_address_i;
      size_q  <= size_clip;
      skip_q  <= skip_in;
      grant_q <= '0;
    end else if (cmd_i.grant) begin
      grant_q <= rd_start;
    end
    if (cmd_i.take_prev) begin
      prev_start_q <= rd_start;
      prev_len_q   <= rd_len;
    end
    if (cmd_i.res_load) begin
      res_status_q  <= (cmd_q == CMD_FREE) ? ST_FREED : (ok_q ? ST_ALLOCATED : ST_NO_FIT);
      res_granted_q <= grant_q;
      res_count_q   <= count_q;
    end
  end

  assign st_o.is_free          = (cmd_q == CMD_FREE);
  assign st_o.skip             = skip_q;
  assign st_o.idx_lt_count     = idx_q < count_q;
  assign st_o.fit              = rd_len >= size_q;
  assign st_o.exact            = rd_len == size_q;
  assign st_o.start_le_addr    = rd_start <= addr_q;
  assign st_o.join_next        = join_next;
  assign st_o.join_prev        = join_prev;
  assign st_o.full             = count_q >= CW'(MAX_SEGMENTS);
  assign st_o.sh_next_lt_count = (CW + 1)'(sh_q) + (CW + 1)'(1) < (CW + 1)'(count_q);
  assign st_o.sh_gt_idx        = sh_q > idx_q;
  assign st_o.out_busy         = out_valid_q && !out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign status_o          = res_status_q;
  assign granted_address_o = res_granted_q;
  assign free_segments_o   = res_count_q;

  `FFAC_ASSERT(a_wr_in_table, cmd_i.wr_en |-> (CW'(wr_idx) <= count_q), "write past table end")
  `FFAC_ASSERT(a_count_step,
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
    (count_q == $past(count_q) - CW'(1)), "segment count jumped")
  `FFAC_NEVER(a_res_overrun, cmd_i.res_load && out_valid_q && !out_ready_i,
    "result overwritten before transfer")
  `FFAC_ASSERT(a_grant_status, (out_valid_q && res_granted_q != '0) |->
    (res_status_q == ST_ALLOCATED), "nonzero address without allocation")

endmodule

>>> sv/first_fit_allocator_coalescing_unit.sv
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing_unit
// First-fit allocator over a pool of POOL_SIZE units with a free-segment
// table sorted by address; frees are merged with touching neighbors.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | fields
//  ---------+---------------------------+-----------------------------------------------
//  request  | in_valid_i / in_ready_o   | command_i, block_address_i, block_size_i
//  result   | out_valid_o / out_ready_i | status_o, granted_address_o, free_segments_o
//
// Flow: one command at a time. A command holds the unit through accept, decode
// and result load, plus one memory read and one compare per table entry visited
// and one read and one write per entry moved when a segment is removed or
// inserted, all on the single table port. A scan that runs off the table end,
// a shift loop and the merge decision on a free each add a step. Entries
// visited plus entries moved never exceed MAX_SEGMENTS.
// Reset: no clearing pass; entry 0 reads as the whole pool until written.
// Stalls: the result sits in an output register, so the next request is
// taken while it waits; only the final hand-off waits on out_ready_i.
// ----------------------------------------------------------------------------
module first_fit_allocator_coalescing_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    command_i,
  input  logic [ffac_pkg::AW-1:0] block_address_i,
  input  logic [ffac_pkg::LW-1:0] block_size_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [ffac_pkg::AW-1:0] granted_address_o,
  output logic [ffac_pkg::CW-1:0] free_segments_o
);
  import ffac_pkg::*;

  // commands from the sequencer, flags back from the datapath
  ctrl_cmd_t  cmd;
  dp_status_t st;

  // Sequencer: walks the scan, chooses the merge case and runs the shift
  // loops that open or close a slot in the table.
  ffac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Datapath: table memory, pointers, segment count and result register.
  ffac_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .command_i         (command_i),
    .block_address_i   (block_address_i),
    .block_size_i      (block_size_i),
    .cmd_i             (cmd),
    .st_o              (st),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .free_segments_o   (free_segments_o)
  );

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_allocator_coalescing_unit: requests go
// through a driver queue, and each reply is checked against a free-segment
// table kept in the bench.
// ----------------------------------------------------------------------------
module tb;
  import ffac_pkg::*;

  // Generous bound: every command at worst-case table cost plus stalls.
  localparam int unsigned CYCLE_LIMIT  = 8_000_000;
  localparam int          RANDOM_ITEMS = 800;
  localparam int          QUIET_ITEMS  = 150;  // tail of the run, no idling
  localparam int          LONG_HOLD    = 600;  // output back-pressure, cycles
  localparam int          SETTLE       = 1100; // > worst-case command latency

  typedef struct packed {
    logic          command;
    logic [AW-1:0] block_address;
    logic [LW-1:0] block_size;
  } request_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [AW-1:0] granted_address;
    logic [CW-1:0] free_segments;
  } reply_t;

  typedef struct packed {
    logic [AW-1:0] base;
    logic [LW-1:0] size;
  } block_t;

  // DUT ports; every input has a known value from time zero.
  logic          clk_i           = 1'b0;
  logic          rst_ni          = 1'b0;
  logic          in_valid_i      = 1'b0;
  logic          in_ready_o;
  logic          command_i       = CMD_ALLOC;
  logic [AW-1:0] block_address_i = '0;
  logic [LW-1:0] block_size_i    = '0;
  logic          out_valid_o;
  logic          out_ready_i     = 1'b0;
  logic [1:0]    status_o;
  logic [AW-1:0] granted_address_o;
  logic [CW-1:0] free_segments_o;

  first_fit_allocator_coalescing_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .block_address_i  (block_address_i),
    .block_size_i     (block_size_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .granted_address_o(granted_address_o),
    .free_segments_o  (free_segments_o)
  );

  // Bench-side copy of the free-segment table, sorted by base address.
  int unsigned seg_base [MAX_SEGMENTS];
  int unsigned seg_len  [MAX_SEGMENTS];
  int unsigned seg_count = 1;

  request_t request_backlog[$]; // waiting for the driver
  reply_t   pending_replies[$]; // predicted, not yet seen on the output
  block_t   live_blocks[$];     // granted and not yet handed back

  int          errors     = 0;
  int unsigned cycles     = 0;
  logic        req_fire   = 1'b0; // request transfer at the last rising edge
  logic        idle_on    = 1'b1; // random bursts of idling on both sides
  logic        hold_go    = 1'b0; // ask the receiver for one long hold-off
  logic        hold_done  = 1'b0;
  int          hold_left  = 0;
  int          tx_gap     = 0;
  int          rx_gap     = 0;

  initial begin
    seg_base[0] = 0;
    seg_len[0]  = POOL_SIZE;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Free-table predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned clip_len(int unsigned v);
    return (v > POOL_SIZE) ? POOL_SIZE : v;
  endfunction

  function automatic void drop_segment(int unsigned k);
    for (int unsigned j = k; j + 1 < seg_count; j++) begin
      seg_base[j] = seg_base[j + 1];
      seg_len[j]  = seg_len[j + 1];
    end
    seg_count--;
  endfunction

  // Applies one command to the table and returns the reply it must produce.
  function automatic reply_t allocator_outcome(request_t req);
    reply_t      rep;
    int unsigned addr;
    int unsigned size;
    int unsigned pos;
    int unsigned len;
    bit          join_next;
    bit          join_prev;
    rep  = '0;
    addr = 32'(req.block_address);
    size = 32'(req.block_size);
    if (req.command == CMD_ALLOC) begin
      rep.status = ST_NO_FIT;
      if (size != 0) begin
        // first fit: lowest base that is large enough
        for (pos = 0; pos < seg_count; pos++)
          if (seg_len[pos] >= size) break;
        if (pos < seg_count) begin
          rep.status          = ST_ALLOCATED;
          rep.granted_address = AW'(seg_base[pos]);
          if (seg_len[pos] == size) begin
            drop_segment(pos);
          end else begin
            seg_len[pos]  -= size;
            seg_base[pos] += size;
          end
        end
      end
    end else begin
      rep.status = ST_FREED;
      // a 9-bit address never lies past the pool, but keep the guard
      if (size != 0 && addr < POOL_SIZE) begin
        if (size > POOL_SIZE - addr) size = POOL_SIZE - addr;
        pos = 0;
        while (pos < seg_count && seg_base[pos] <= addr) pos++;
        len       = size;
        join_next = (pos < seg_count) && (seg_base[pos] == addr + size);
        if (join_next) len = clip_len(len + seg_len[pos]);
        join_prev = (pos > 0) && (seg_base[pos - 1] + seg_len[pos - 1] == addr);
        if (join_prev) begin
          seg_len[pos - 1] = clip_len(seg_len[pos - 1] + len);
          if (join_next) drop_segment(pos);
        end else if (join_next) begin
          seg_base[pos] = addr;
          seg_len[pos]  = len;
        end else if (seg_count < MAX_SEGMENTS) begin
          for (int unsigned j = seg_count; j > pos; j--) begin
            seg_base[j] = seg_base[j - 1];
            seg_len[j]  = seg_len[j - 1];
          end
          seg_base[pos] = addr;
          seg_len[pos]  = len;
          seg_count++;
        end
        // isolated block on a full table is silently dropped
      end
    end
    rep.free_segments = CW'(seg_count);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: request channel, changes on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_fire) begin
      // slot is free: idle for a while, or present the next request
      if (tx_gap > 0) begin
        in_valid_i <= 1'b0;
        tx_gap     <= tx_gap - 1;
      end else if (request_backlog.size() != 0) begin
        request_t r;
        r = request_backlog.pop_front();
        command_i       <= r.command;
        block_address_i <= r.block_address;
        block_size_i    <= r.block_size;
        in_valid_i      <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 14);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // unit fills its result register and has to refuse new requests.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_left   <= LONG_HOLD;
      hold_done   <= 1'b1;
    end else if (rx_gap > 0) begin
      out_ready_i <= 1'b0;
      rx_gap      <= rx_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 14);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    reply_t   want;
    request_t req;
    block_t   grant_blk;
    req_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      // result side first; it can never belong to a request taken this edge
      if (out_valid_o && out_ready_i) begin
        if (pending_replies.size() == 0) begin
          $error("result transfer with nothing expected: status %0d addr %0d segs %0d",
                 status_o, granted_address_o, free_segments_o);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            errors++;
          end
          if (granted_address_o !== want.granted_address) begin
            $error("granted_address: expected %0d, actual %0d",
                   want.granted_address, granted_address_o);
            errors++;
          end
          if (free_segments_o !== want.free_segments) begin
            $error("free_segments: expected %0d, actual %0d",
                   want.free_segments, free_segments_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        req.command       = command_i;
        req.block_address = block_address_i;
        req.block_size    = block_size_i;
        want = allocator_outcome(req);
        pending_replies.insert(pending_replies.size(), want);
        // remember grants so the stimulus can hand them back later
        if (want.status == ST_ALLOCATED) begin
          grant_blk.base = want.granted_address;
          grant_blk.size = block_size_i;
          live_blocks.insert(live_blocks.size(), grant_blk);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_request(input logic cmd, input int unsigned addr,
                               input int unsigned size);
    request_t r;
    while (request_backlog.size() >= 4) @(negedge clk_i);
    r.command       = cmd;
    r.block_address = AW'(addr);
    r.block_size    = LW'(size);
    request_backlog.insert(request_backlog.size(), r);
  endtask

  // Wait until every request is taken and every reply has come back.
  task automatic drain();
    while (request_backlog.size() != 0 || in_valid_i || pending_replies.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    int unsigned k;
    int unsigned cut;
    int unsigned sel;
    int unsigned sz;
    block_t      blk;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed: corner cases, table whole again at the end ----
    queue_request(CMD_ALLOC, 0, 0);       // zero-size allocate: no fit
    queue_request(CMD_ALLOC, 511, 1023);  // oversized, all ones
    queue_request(CMD_ALLOC, 0, 513);     // just past the pool
    queue_request(CMD_ALLOC, 0, 512);     // exact fit on whole pool -> empty
    queue_request(CMD_ALLOC, 0, 1);       // empty table: no fit
    queue_request(CMD_FREE, 0, 0);        // zero-size free: no change
    queue_request(CMD_FREE, 511, 1023);   // runs past the end, clipped to 1
    queue_request(CMD_FREE, 0, 100);      // isolated insert in front
    queue_request(CMD_FREE, 100, 411);    // joins both sides
    queue_request(CMD_ALLOC, 0, 100);     // cut from the front
    queue_request(CMD_ALLOC, 0, 50);
    queue_request(CMD_FREE, 0, 50);       // no neighbor
    queue_request(CMD_FREE, 100, 50);     // joins following segment
    queue_request(CMD_FREE, 50, 50);      // joins both sides
    queue_request(CMD_ALLOC, 0, 256);
    queue_request(CMD_ALLOC, 0, 300);     // no segment large enough
    queue_request(CMD_FREE, 0, 256);
    queue_request(CMD_FREE, 200, 100);    // overlaps a free segment
    queue_request(CMD_FREE, 300, 212);    // joins the overlapping one
    queue_request(CMD_ALLOC, 0, 512);
    queue_request(CMD_ALLOC, 0, 312);
    queue_request(CMD_FREE, 0, 512);      // back to one whole segment
    drain();
    live_blocks.delete();

    // ---- fill the table: unit blocks, every other one handed back ----
    for (int i = 0; i < POOL_SIZE; i++) queue_request(CMD_ALLOC, 0, 1);
    queue_request(CMD_ALLOC, 0, 1);       // empty table
    for (int i = 0; i < POOL_SIZE; i += 2) queue_request(CMD_FREE, i, 1);
    queue_request(CMD_FREE, 0, 1);        // full table, no neighbor: dropped
    queue_request(CMD_FREE, 100, 1);      // same again mid-table
    queue_request(CMD_ALLOC, 0, 2);       // scans all entries, no fit
    queue_request(CMD_ALLOC, 0, 1);       // exact fit at the front
    queue_request(CMD_FREE, 0, 1);        // insert at the front
    for (int i = 1; i < POOL_SIZE; i += 2) queue_request(CMD_FREE, i, 1);
    drain();
    live_blocks.delete();

    // ---- random: mostly allocate/free of real grants, some noise ----
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      else if (n % 100 == 0 && n < RANDOM_ITEMS - QUIET_ITEMS)
        idle_on = ($urandom_range(0, 3) != 0);
      if (n == 300) hold_go = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick >= 45 && pick < 88 && live_blocks.size() != 0) begin
        k   = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[k];
        live_blocks.delete(k);
        if (pick >= 80 && blk.size > 1) begin
          // hand back in two pieces, tail first
          cut = $urandom_range(1, blk.size - 1);
          queue_request(CMD_FREE, blk.base + cut, blk.size - cut);
          queue_request(CMD_FREE, blk.base, cut);
        end else begin
          queue_request(CMD_FREE, blk.base, blk.size);
        end
      end else if (pick >= 88) begin
        // arbitrary free: may overlap, double free or run off the end
        queue_request(CMD_FREE, $urandom_range(0, 511), $urandom_range(0, 1023));
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 14)       sz = $urandom_range(1, 32);
        else if (sel < 18)  sz = $urandom_range(1, 160);
        else if (sel == 18) sz = $urandom_range(161, 512);
        else                sz = $urandom_range(0, 1023);
        queue_request(CMD_ALLOC, $urandom_range(0, 511), sz);
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
